// File: design/rti_pkg.sv
// rti_pkg: types, constants and saturating fixed point helpers for the
// ray and triangle intersection core; no dependencies
package rti_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int QUO_WIDTH   = COORD_WIDTH + FRAC_BITS;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [COORD_WIDTH-1:0]        t_umag;
    typedef logic [2*COORD_WIDTH-1:0]      t_wide;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_wide  LIM_POS   = {{(COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam t_wide  LIM_NEG   = {{COORD_WIDTH{1'b0}}, 1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam t_coord ORIGIN_X_RST = t_coord'(32768);
    localparam t_coord ORIGIN_Y_RST = t_coord'(32768);
    localparam t_coord ORIGIN_Z_RST = t_coord'(-65536);

    typedef enum logic [1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_ORIGIN_Z = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef struct packed {
        t_coord target_x;
        t_coord target_y;
        t_coord target_z;
        t_coord vertex_a_x;
        t_coord vertex_a_y;
        t_coord vertex_a_z;
        t_coord vertex_b_x;
        t_coord vertex_b_y;
        t_coord vertex_b_z;
        t_coord vertex_c_x;
        t_coord vertex_c_y;
        t_coord vertex_c_z;
    } t_in;

    typedef struct packed {
        t_coord ray_param;
        t_coord normal_x;
        t_coord normal_y;
        t_coord normal_z;
        t_coord hit_x;
        t_coord hit_y;
        t_coord hit_z;
        logic   inside_res;
    } t_out;

    typedef struct packed {
        logic  neg;
        t_wide mag;
    } t_prod;

    typedef t_prod [5:0] t_prod6;
    typedef t_prod [2:0] t_prod3;

    typedef struct packed {
        t_vec a;
        t_vec b;
        t_vec c;
        t_vec e;
        t_vec dir;
        t_vec n;
    } t_ctx;

    function automatic t_coord sat_add(t_coord a, t_coord b);
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        end
        return s[COORD_WIDTH-1:0];
    endfunction

    function automatic t_coord sat_sub(t_coord a, t_coord b);
        logic signed [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1]) begin
            return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        end
        return s[COORD_WIDTH-1:0];
    endfunction

    function automatic t_vec vec_sub(t_vec a, t_vec b);
        t_vec r;
        r.x = sat_sub(a.x, b.x);
        r.y = sat_sub(a.y, b.y);
        r.z = sat_sub(a.z, b.z);
        return r;
    endfunction

    function automatic t_umag abs_mag(t_coord a);
        t_umag u;
        u = a;
        return a[COORD_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

    // sign and magnitude to saturated coordinate
    function automatic t_coord pack_wide(logic neg, t_wide m);
        t_umag lo;
        lo = m[COORD_WIDTH-1:0];
        if (neg) begin
            if (m > LIM_NEG) return COORD_MIN;
            return $signed(~lo + 1'b1);
        end
        if (m > LIM_POS) return COORD_MAX;
        return $signed(lo);
    endfunction

    function automatic t_prod mul_raw(t_coord a, t_coord b);
        t_prod p;
        p.neg = a[COORD_WIDTH-1] ^ b[COORD_WIDTH-1];
        p.mag = {{COORD_WIDTH{1'b0}}, abs_mag(a)} * {{COORD_WIDTH{1'b0}}, abs_mag(b)};
        return p;
    endfunction

    function automatic t_coord prod_pack(t_prod p);
        return pack_wide(p.neg, p.mag >> FRAC_BITS);
    endfunction

    function automatic t_prod6 cross_raw(t_vec p, t_vec q);
        t_prod6 r;
        r[0] = mul_raw(p.y, q.z);
        r[1] = mul_raw(p.z, q.y);
        r[2] = mul_raw(p.z, q.x);
        r[3] = mul_raw(p.x, q.z);
        r[4] = mul_raw(p.x, q.y);
        r[5] = mul_raw(p.y, q.x);
        return r;
    endfunction

    function automatic t_vec cross_pack(t_prod6 r);
        t_vec v;
        v.x = sat_sub(prod_pack(r[0]), prod_pack(r[1]));
        v.y = sat_sub(prod_pack(r[2]), prod_pack(r[3]));
        v.z = sat_sub(prod_pack(r[4]), prod_pack(r[5]));
        return v;
    endfunction

    function automatic t_prod3 dot_raw(t_vec p, t_vec q);
        t_prod3 r;
        r[0] = mul_raw(p.x, q.x);
        r[1] = mul_raw(p.y, q.y);
        r[2] = mul_raw(p.z, q.z);
        return r;
    endfunction

endpackage

// File: design/ray_triangle_intersect_core.sv
// ray_triangle_intersect_core: top level of the fixed point ray and triangle
// intersection pipeline; uses rti_pkg, rti_front, rti_div and rti_back
//
// Usage:
//   An item (ray target and three triangle vertices) is taken at each rising
//   edge with i_start high; o_busy stays low, so one item per cycle streams in.
//   The ray origin comes from three registers on the config channel
//   (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data); o_cfg_ready is
//   always high and an index past the origin z register is ignored.
//   Change the origin only while no item is in flight.
//   Each item gives one result on o_res, shown for a single cycle with
//   o_res_valid high, after it has passed the front stages for the normal
//   and the dot products, the divider (one quotient bit per stage over 48
//   stages) and the back stages for the hit point and inside test.
//   Throughput is one item per cycle.
//   The receiver cannot stall; results go out on their fixed cycle.
//   Synchronous active-low reset drops every item in flight and loads the
//   origin with (0.5, 0.5, -1.0).
module ray_triangle_intersect_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  rti_pkg::t_in       i_item,
    output logic               o_res_valid,
    output rti_pkg::t_out      o_res,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  rti_pkg::t_coord    i_cfg_data
);

    localparam int LATENCY = 65;

    rti_pkg::t_vec   r_origin;
    logic            f_valid, d_valid;
    rti_pkg::t_ctx   f_ctx, d_ctx;
    rti_pkg::t_coord f_num, f_den, d_u;
    logic            d_dz;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin.x <= rti_pkg::ORIGIN_X_RST;
            r_origin.y <= rti_pkg::ORIGIN_Y_RST;
            r_origin.z <= rti_pkg::ORIGIN_Z_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rti_pkg::REG_ORIGIN_X: r_origin.x <= i_cfg_data;
                rti_pkg::REG_ORIGIN_Y: r_origin.y <= i_cfg_data;
                rti_pkg::REG_ORIGIN_Z: r_origin.z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rti_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_start && !o_busy),
        .i_item   (i_item),
        .i_origin (r_origin),
        .o_valid  (f_valid),
        .o_ctx    (f_ctx),
        .o_num    (f_num),
        .o_den    (f_den)
    );

    rti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_ctx   (f_ctx),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_valid (d_valid),
        .o_ctx   (d_ctx),
        .o_u     (d_u),
        .o_dz    (d_dz)
    );

    rti_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_ctx   (d_ctx),
        .i_u     (d_u),
        .i_dz    (d_dz),
        .o_valid (o_res_valid),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_res_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(i_start, LATENCY))
        else $error("result without an item taken");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result after reset");

    a_cfg_write_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == rti_pkg::REG_ORIGIN_X) |=>
        (r_origin.x == $past(i_cfg_data)))
        else $error("origin x not written");

    a_dz_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_valid && d_dz) |-> (d_u == rti_pkg::COORD_MAX || d_u == rti_pkg::COORD_MIN))
        else $error("zero denominator without saturated parameter");
`endif

endmodule

// File: design/rti_front.sv
// rti_front: edge vectors, plane normal and the numerator and denominator
// of the ray parameter, six register stages; uses rti_pkg
module rti_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rti_pkg::t_in   i_item,
    input  rti_pkg::t_vec  i_origin,
    output logic           o_valid,
    output rti_pkg::t_ctx  o_ctx,
    output rti_pkg::t_coord o_num,
    output rti_pkg::t_coord o_den
);

    logic [5:0]      r_vld;
    rti_pkg::t_ctx   r_ctx [1:6];
    rti_pkg::t_vec   r_ba, r_ca;
    rti_pkg::t_vec   r_ae [1:3];
    rti_pkg::t_prod6 r_pn;
    rti_pkg::t_prod3 r_pnum, r_pden;
    rti_pkg::t_coord r_snum, r_tnum, r_sden, r_tden, r_num, r_den;
    rti_pkg::t_ctx   n_ctx1;
    rti_pkg::t_ctx   n_ctx3;
    rti_pkg::t_vec   n_s;

    always_comb begin
        n_s.x      = i_item.target_x;
        n_s.y      = i_item.target_y;
        n_s.z      = i_item.target_z;
        n_ctx1.a.x = i_item.vertex_a_x;
        n_ctx1.a.y = i_item.vertex_a_y;
        n_ctx1.a.z = i_item.vertex_a_z;
        n_ctx1.b.x = i_item.vertex_b_x;
        n_ctx1.b.y = i_item.vertex_b_y;
        n_ctx1.b.z = i_item.vertex_b_z;
        n_ctx1.c.x = i_item.vertex_c_x;
        n_ctx1.c.y = i_item.vertex_c_y;
        n_ctx1.c.z = i_item.vertex_c_z;
        n_ctx1.e   = i_origin;
        n_ctx1.dir = rti_pkg::vec_sub(n_s, i_origin);
        n_ctx1.n   = '0;
    end

    always_comb begin
        n_ctx3   = r_ctx[2];
        n_ctx3.n = rti_pkg::cross_pack(r_pn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctx[1] <= n_ctx1;
        r_ba     <= rti_pkg::vec_sub(n_ctx1.b, n_ctx1.a);
        r_ca     <= rti_pkg::vec_sub(n_ctx1.c, n_ctx1.a);
        r_ae[1]  <= rti_pkg::vec_sub(n_ctx1.a, i_origin);

        r_ctx[2] <= r_ctx[1];
        r_ae[2]  <= r_ae[1];
        r_pn     <= rti_pkg::cross_raw(r_ba, r_ca);

        r_ctx[3] <= n_ctx3;
        r_ae[3]  <= r_ae[2];

        r_ctx[4] <= r_ctx[3];
        r_pnum   <= rti_pkg::dot_raw(r_ctx[3].n, r_ae[3]);
        r_pden   <= rti_pkg::dot_raw(r_ctx[3].n, r_ctx[3].dir);

        r_ctx[5] <= r_ctx[4];
        r_snum   <= rti_pkg::sat_add(rti_pkg::prod_pack(r_pnum[0]),
                                     rti_pkg::prod_pack(r_pnum[1]));
        r_tnum   <= rti_pkg::prod_pack(r_pnum[2]);
        r_sden   <= rti_pkg::sat_add(rti_pkg::prod_pack(r_pden[0]),
                                     rti_pkg::prod_pack(r_pden[1]));
        r_tden   <= rti_pkg::prod_pack(r_pden[2]);

        r_ctx[6] <= r_ctx[5];
        r_num    <= rti_pkg::sat_add(r_snum, r_tnum);
        r_den    <= rti_pkg::sat_add(r_sden, r_tden);
    end

    assign o_valid = r_vld[5];
    assign o_ctx   = r_ctx[6];
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

// File: design/rti_div.sv
// rti_div: pipelined restoring divider for the ray parameter, one quotient
// bit per stage, with saturation; uses rti_pkg
module rti_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rti_pkg::t_ctx   i_ctx,
    input  rti_pkg::t_coord i_num,
    input  rti_pkg::t_coord i_den,
    output logic            o_valid,
    output rti_pkg::t_ctx   o_ctx,
    output rti_pkg::t_coord o_u,
    output logic            o_dz
);

    localparam int STEPS = rti_pkg::QUO_WIDTH;

    typedef struct packed {
        rti_pkg::t_umag                 rem;
        logic [rti_pkg::QUO_WIDTH-1:0]  quo;
        logic [rti_pkg::QUO_WIDTH-1:0]  dvd;
        rti_pkg::t_umag                 dsr;
        logic                           neg;
        logic                           dz;
        logic                           nneg;
    } t_dst;

    t_dst            r_st  [0:STEPS];
    rti_pkg::t_ctx   r_ctx [0:STEPS];
    logic [STEPS:0]  r_vld;
    logic            r_out_vld;
    rti_pkg::t_ctx   r_out_ctx;
    rti_pkg::t_coord r_u;
    logic            r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[STEPS-1:0], i_valid};
            r_out_vld <= r_vld[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0].rem  <= '0;
        r_st[0].quo  <= '0;
        r_st[0].dvd  <= {rti_pkg::abs_mag(i_num), {rti_pkg::FRAC_BITS{1'b0}}};
        r_st[0].dsr  <= rti_pkg::abs_mag(i_den);
        r_st[0].neg  <= i_num[rti_pkg::COORD_WIDTH-1] ^ i_den[rti_pkg::COORD_WIDTH-1];
        r_st[0].dz   <= (i_den == '0);
        r_st[0].nneg <= !i_num[rti_pkg::COORD_WIDTH-1];
        r_ctx[0]     <= i_ctx;
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        t_dst                             n_st;
        logic [rti_pkg::COORD_WIDTH:0]    trial;
        logic [rti_pkg::COORD_WIDTH:0]    diff;
        logic                             ge;

        always_comb begin
            trial    = {r_st[k-1].rem, r_st[k-1].dvd[rti_pkg::QUO_WIDTH-1]};
            diff     = trial - {1'b0, r_st[k-1].dsr};
            ge       = trial >= {1'b0, r_st[k-1].dsr};
            n_st     = r_st[k-1];
            n_st.rem = ge ? diff[rti_pkg::COORD_WIDTH-1:0] : trial[rti_pkg::COORD_WIDTH-1:0];
            n_st.quo = {r_st[k-1].quo[rti_pkg::QUO_WIDTH-2:0], ge};
            n_st.dvd = {r_st[k-1].dvd[rti_pkg::QUO_WIDTH-2:0], 1'b0};
        end

        always_ff @(posedge i_clk) begin
            r_st[k]  <= n_st;
            r_ctx[k] <= r_ctx[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ctx <= r_ctx[STEPS];
        r_dz      <= r_st[STEPS].dz;
        if (r_st[STEPS].dz) begin
            r_u <= r_st[STEPS].nneg ? rti_pkg::COORD_MAX : rti_pkg::COORD_MIN;
        end else begin
            r_u <= rti_pkg::pack_wide(r_st[STEPS].neg,
                {{(2*rti_pkg::COORD_WIDTH-rti_pkg::QUO_WIDTH){1'b0}}, r_st[STEPS].quo});
        end
    end

    assign o_valid = r_out_vld;
    assign o_ctx   = r_out_ctx;
    assign o_u     = r_u;
    assign o_dz    = r_dz;

endmodule

// File: design/rti_back.sv
// rti_back: hit point, vertex vectors, cyclic crosses and dots, and the
// inside decision, nine register stages; uses rti_pkg
module rti_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  rti_pkg::t_ctx   i_ctx,
    input  rti_pkg::t_coord i_u,
    input  logic            i_dz,
    output logic            o_valid,
    output rti_pkg::t_out   o_res
);

    typedef struct packed {
        rti_pkg::t_coord u;
        rti_pkg::t_vec   n;
        rti_pkg::t_vec   hit;
        logic            dz;
    } t_keep;

    logic [8:0]      r_vld;
    rti_pkg::t_ctx   r_ctx1;
    t_keep           r_kp [1:8];
    rti_pkg::t_prod3 r_ph;
    rti_pkg::t_vec   r_a2, r_b2, r_c2;
    rti_pkg::t_vec   r_va, r_vb, r_vc;
    rti_pkg::t_prod6 r_px1, r_px2, r_px3;
    rti_pkg::t_vec   r_c1, r_cc2, r_c3;
    rti_pkg::t_prod3 r_pd [0:2];
    rti_pkg::t_coord r_s [0:2];
    rti_pkg::t_coord r_t [0:2];
    rti_pkg::t_coord r_d [0:2];
    rti_pkg::t_out   r_res;
    logic            n_inside;
    t_keep           n_kp2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], i_valid};
        end
    end

    always_comb begin
        n_kp2       = r_kp[1];
        n_kp2.hit.x = rti_pkg::sat_add(r_ctx1.e.x, rti_pkg::prod_pack(r_ph[0]));
        n_kp2.hit.y = rti_pkg::sat_add(r_ctx1.e.y, rti_pkg::prod_pack(r_ph[1]));
        n_kp2.hit.z = rti_pkg::sat_add(r_ctx1.e.z, rti_pkg::prod_pack(r_ph[2]));
    end

    always_ff @(posedge i_clk) begin
        r_ctx1     <= i_ctx;
        r_kp[1].u  <= i_u;
        r_kp[1].n  <= i_ctx.n;
        r_kp[1].hit <= '0;
        r_kp[1].dz <= i_dz;
        r_ph[0]    <= rti_pkg::mul_raw(i_ctx.dir.x, i_u);
        r_ph[1]    <= rti_pkg::mul_raw(i_ctx.dir.y, i_u);
        r_ph[2]    <= rti_pkg::mul_raw(i_ctx.dir.z, i_u);

        r_kp[2] <= n_kp2;
        r_a2    <= r_ctx1.a;
        r_b2    <= r_ctx1.b;
        r_c2    <= r_ctx1.c;

        r_kp[3] <= r_kp[2];
        r_va    <= rti_pkg::vec_sub(r_a2, r_kp[2].hit);
        r_vb    <= rti_pkg::vec_sub(r_b2, r_kp[2].hit);
        r_vc    <= rti_pkg::vec_sub(r_c2, r_kp[2].hit);

        r_kp[4] <= r_kp[3];
        r_px1   <= rti_pkg::cross_raw(r_va, r_vb);
        r_px2   <= rti_pkg::cross_raw(r_vb, r_vc);
        r_px3   <= rti_pkg::cross_raw(r_vc, r_va);

        r_kp[5] <= r_kp[4];
        r_c1    <= rti_pkg::cross_pack(r_px1);
        r_cc2   <= rti_pkg::cross_pack(r_px2);
        r_c3    <= rti_pkg::cross_pack(r_px3);

        r_kp[6]  <= r_kp[5];
        r_pd[0]  <= rti_pkg::dot_raw(r_c1, r_cc2);
        r_pd[1]  <= rti_pkg::dot_raw(r_cc2, r_c3);
        r_pd[2]  <= rti_pkg::dot_raw(r_c3, r_c1);

        r_kp[7] <= r_kp[6];
        r_kp[8] <= r_kp[7];
        for (int i = 0; i < 3; i++) begin
            r_s[i] <= rti_pkg::sat_add(rti_pkg::prod_pack(r_pd[i][0]),
                                       rti_pkg::prod_pack(r_pd[i][1]));
            r_t[i] <= rti_pkg::prod_pack(r_pd[i][2]);
            r_d[i] <= rti_pkg::sat_add(r_s[i], r_t[i]);
        end

        r_res.ray_param  <= r_kp[8].u;
        r_res.normal_x   <= r_kp[8].n.x;
        r_res.normal_y   <= r_kp[8].n.y;
        r_res.normal_z   <= r_kp[8].n.z;
        r_res.hit_x      <= r_kp[8].hit.x;
        r_res.hit_y      <= r_kp[8].hit.y;
        r_res.hit_z      <= r_kp[8].hit.z;
        r_res.inside_res <= n_inside;
    end

    // strictly positive dots only, and no zero denominator
    always_comb begin
        n_inside = !r_kp[8].dz;
        for (int i = 0; i < 3; i++) begin
            n_inside = n_inside && !r_d[i][rti_pkg::COORD_WIDTH-1] && (r_d[i] != '0);
        end
    end

    assign o_valid = r_vld[8];
    assign o_res   = r_res;

endmodule
